### rtl/core/sitda_pkg.sv
// sitda_pkg: shared types and constants of the signed integer to decimal ASCII unit.
// Depends on nothing; imported by signed_int_to_decimal_ascii_unit and decimal_text_checker.
package sitda_pkg;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SKIP = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [3:0] BCD_FIVE    = 4'd5;
   localparam logic [3:0] BCD_THREE   = 4'd3;

endpackage

### rtl/core/signed_int_to_decimal_ascii_unit.sv
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text, one character a word.
// Depends on sitda_pkg (state type, ASCII and BCD constants).
//
//  channel  direction  ports                          word contents
//  req      in         req_tvalid/tready/tdata        value (VALUE_BITS, signed)
//  rsp      out        rsp_tvalid/tready/tdata/tlast  character (8 bits), last in tlast
//
// Steps: take the word, VALUE_BITS shift-and-add-3 steps of the shared
// BCD unit (double dabble), one skip step per leading zero digit plus one to
// leave the skip state, one step for the sign when negative, then one per digit sent.
// Reset clears the sequencer and rsp_tvalid; data registers are not reset.
// A stall on rsp holds the sequencer in its sign or emit state; req_tready is
// high only in idle, which may overlap the last character still waiting.
module signed_int_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: [VALUE_BITS-1:0] value, zero-filled to whole bytes
   input  logic [8*((VALUE_BITS+7)/8)-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: [7:0] character
   output logic [7:0]                          rsp_tdata,
   output logic                                rsp_tlast
);
   import sitda_pkg::*;

   // decimal digits needed for a VALUE_BITS magnitude (1233/4096 ~ log10 2)
   localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_W  = 4 * DIGITS;
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int DIG_W  = $clog2(DIGITS + 1);

   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIG_W-1:0]       dig_left_ff, dig_left_in;
   logic                   neg_ff, neg_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   logic [VALUE_BITS-1:0]  raw;
   logic [3:0]             top_digit;
   logic                   slot_free;
   logic                   last_digit;

   assign raw        = req_tdata[VALUE_BITS-1:0];
   assign top_digit  = bcd_ff[BCD_W-1 -: 4];
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign last_digit = (dig_left_ff == DIG_W'(1));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   // shared unit: add 3 to every BCD digit of 5 or more (digits independent)
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= BCD_FIVE) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + BCD_THREE;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      dig_left_in  = dig_left_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in   = raw[VALUE_BITS-1];
               // most negative value wraps to 2^(VALUE_BITS-1), exact as unsigned
               mag_in   = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               dig_left_in = DIG_W'(DIGITS);
               state_in    = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if ((top_digit == 4'd0) && !last_digit) begin
               bcd_in      = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_left_in = dig_left_ff - DIG_W'(1);
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_ZERO + {4'd0, top_digit};
               out_last_in  = last_digit;
               bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_left_in  = dig_left_ff - DIG_W'(1);
               if (last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      dig_left_ff <= dig_left_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

### test/decimal_text_checker.sv
// decimal_text_checker: watches both word channels of the decimal ASCII unit,
// predicts the text of every accepted integer and compares it character by character.
// Depends on sitda_pkg (ASCII constants).
module decimal_text_checker #(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [VALUE_BITS-1:0]   req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [7:0]              rsp_tdata,
   input  logic                    rsp_tlast,
   output int                      failures,
   output int                      pending,
   output int                      words_seen,
   output int                      chars_seen
);
   import sitda_pkg::*;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];

   initial begin
      failures   = 0;
      words_seen = 0;
      chars_seen = 0;
   end

   assign pending = expected_text.size();

   // sign first, then digits most significant first; the magnitude is taken as
   // an unsigned quantity so the most negative value converts exactly
   function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value);
      logic [VALUE_BITS-1:0] magnitude;
      logic [7:0]            digits[$];
      text_char_type         entry;
      magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      do begin
         digits.push_front(ASCII_ZERO + 8'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[VALUE_BITS-1]) begin
         entry.character = ASCII_MINUS;
         entry.last      = 1'b0;
         expected_text.push_back(entry);
      end
      foreach (digits[i]) begin
         entry.character = digits[i];
         entry.last      = (i == digits.size() - 1);
         expected_text.push_back(entry);
      end
   endfunction

   // a character accepted on the same edge as a new integer belongs to the
   // previous integer, so compare before predicting
   always @(posedge clock) begin
      text_char_type oldest;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            chars_seen++;
            if (expected_text.size() == 0) begin
               $error("unexpected character %h (last %b) with nothing pending",
                      rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               oldest = expected_text.pop_front();
               if (rsp_tdata !== oldest.character) begin
                  $error("character: expected %h got %h", oldest.character, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== oldest.last) begin
                  $error("last: expected %b got %b", oldest.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            words_seen++;
            predict_decimal_text(req_tdata);
         end
      end
   end

endmodule

### test/signed_int_to_decimal_ascii_unit_tb.sv
// signed_int_to_decimal_ascii_unit_tb: stimulus, flow control and verdict for the
// decimal ASCII unit. Depends on the unit, sitda_pkg and decimal_text_checker.
module signed_int_to_decimal_ascii_unit_tb;

   localparam int VALUE_BITS     = 32;
   localparam int RANDOM_WORDS   = 80;    // per flow-control phase
   localparam int DRAIN_CYCLES   = 60;    // a bit more than one full conversion
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [VALUE_BITS-1:0] req_tdata  = '0;   // [31:0] value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // [7:0] character
   logic                  rsp_tlast;

   int failures;
   int pending;
   int words_seen;
   int chars_seen;
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles      = 0;

   // 12 time unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   signed_int_to_decimal_ascii_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   decimal_text_checker #(
      .VALUE_BITS (VALUE_BITS)
   ) text_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .pending    (pending),
      .words_seen (words_seen),
      .chars_seen (chars_seen)
   );

   // receiver back-pressure, redrawn every cycle; zero percent means always ready
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog: stalls add only short random runs to a conversion,
   // so a long stretch with no word moving means the unit is stuck
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // offer one integer; valid stays high into the next call unless that call idles
   task automatic send_integer(input logic [VALUE_BITS-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // random integers weighted toward the interesting corners: digit-count
   // boundaries, the signed extremes and short numbers, plus plain random words
   function automatic logic [VALUE_BITS-1:0] random_integer();
      logic [VALUE_BITS-1:0] value;
      logic [VALUE_BITS-1:0] power_of_ten;
      int                    exponent;
      power_of_ten = 1;
      case ($urandom_range(4))
         0: value = $urandom;
         1: value = $urandom_range(999);
         2: begin
            exponent = $urandom_range(9);
            for (int k = 0; k < exponent; k++) power_of_ten = power_of_ten * 10;
            value = power_of_ten + $urandom_range(2) - 1;
         end
         3: value = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(20)
                                      : 32'h8000_0000 + $urandom_range(20);
         default: value = $urandom >> $urandom_range(31);
      endcase
      if (value[VALUE_BITS-1] == 1'b0 && $urandom_range(1)) value = -value;
      return value;
   endfunction

   // sign, single digit, some digit-count boundaries and both signed extremes
   logic [VALUE_BITS-1:0] directed_values[] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd12345, -32'sd12345, 32'd999999999, 32'd1000000000, -32'sd1000000000,
      32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFE,
      32'd1234567890, -32'sd1999999999
   };

   int sender_pcts[4]   = '{0, 59, 0, 9};
   int receiver_pcts[4] = '{0, 0, 59, 9};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_pcts[phase];
         receiver_stall_pct = receiver_pcts[phase];
         if (phase == 0) begin
            foreach (directed_values[i]) send_integer(directed_values[i]);
         end
         for (int n = 0; n < RANDOM_WORDS; n++) send_integer(random_integer());
      end
      req_tvalid <= 1'b0;

      // let every character arrive, then watch a little longer for strays
      receiver_stall_pct = 0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d integers into %0d characters across four flow-control mixes,",
               words_seen, chars_seen);
      $display("signed extremes, zero and every digit count included");
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", failures);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
